// ----- rtl/linear_ramp_generator_core_assert.svh -----
// Assertion macros for the linear ramp generator checker.
// Each macro clocks on clk and is disabled while rst is high.
`ifndef LINEAR_RAMP_GENERATOR_CORE_ASSERT_SVH
`define LINEAR_RAMP_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication
`define LRG_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("linear ramp generator check failed");

// next-cycle implication
`define LRG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("linear ramp generator check failed");

`endif

// ----- rtl/lrg_pkg.sv -----
// Package for the linear ramp generator: widths, reset values, commands, sequencer states.
// No dependencies.
`default_nettype none

package lrg_pkg;

  localparam int ACC_FRAC_BITS_DEF = 32;
  localparam int Q_W               = 32;
  localparam int TIME_W            = 16;
  localparam int TPM_W             = 8;
  localparam int N_W               = TIME_W + TPM_W;
  localparam logic [TPM_W-1:0] TPM_RESET = 8'd48;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_STOP = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_TICK = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/linear_ramp_generator_core.sv -----
// Linear ramp generator core: ramp sequencer with a restoring divider.
// Depends on lrg_pkg.
//
// Channels: s_* takes one item per transfer, s_tuser is the command (0 = tick
// with target and time, 1 = stop). m_* returns one sample per tick item; a
// stop item returns nothing. cfg_* writes ticks_per_ms, accepted every cycle.
// Sequence: a tick that keeps the target or jumps passes through ST_TICK,
// where the sample is registered, to ST_OUT. A tick that starts a ramp runs
// the divider in ST_DIV first. A stop item leaves the core idle.
// Throughput: one item at a time; s_tready is high only while idle, so a tick
// item holds off new items until its sample is taken on m_tready.
// The radix-2 subtract-and-shift divider sets the length of a retarget.
// Reset: synchronous on rst; value, targets, step and tick count clear to zero,
// ticks_per_ms returns to 48, no sample is pending.
// Stall: the sample holds on m_tdata with m_tvalid high until m_tready; no new
// item is taken meanwhile.
`default_nettype none

module linear_ramp_generator_core #(
  parameter int ACC_FRAC_BITS = lrg_pkg::ACC_FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [47:0]                   s_tdata,  // target[31:0], time_ms[47:32]
  input  wire logic                          s_tuser,  // cmd[0]
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [31:0]                        m_tdata,  // sample[31:0]
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [lrg_pkg::TPM_W-1:0]     cfg_data
);

  localparam int ACC_W = 16 + ACC_FRAC_BITS;
  localparam int SHIFT = ACC_FRAC_BITS - 16;
  localparam int DW    = ACC_W + 1;
  localparam int CNT_W = $clog2(DW + 1);
  localparam int N_W   = lrg_pkg::N_W;
  localparam int Q_W   = lrg_pkg::Q_W;

  lrg_pkg::state_t state, state_next;

  logic [lrg_pkg::TPM_W-1:0] ticks_per_ms;
  logic signed [ACC_W-1:0]   accum_value;
  logic signed [Q_W-1:0]     ramp_target;
  logic signed [Q_W-1:0]     last_target;
  logic signed [DW-1:0]      step_size;
  logic [N_W-1:0]            ticks_remaining;
  logic [DW-1:0]             dvd;
  logic [N_W-1:0]            rem;
  logic                      neg;
  logic [CNT_W-1:0]          cnt;
  logic [Q_W-1:0]            sample;

  logic                      cmd;
  logic signed [Q_W-1:0]     in_target;
  logic [lrg_pkg::TIME_W-1:0] in_time;
  logic                      s_fire;
  logic [N_W-1:0]            n_raw;
  logic [N_W-1:0]            n_val;
  logic signed [DW-1:0]      diff;
  logic [DW-1:0]             diff_mag;
  logic signed [ACC_W-1:0]   acc_sh;
  logic signed [ACC_W-1:0]   tgt_acc;
  logic signed [ACC_W-1:0]   ramp_acc;
  logic [N_W:0]              trial;
  logic                      qbit;

  assign cmd       = s_tuser;
  assign in_target = s_tdata[31:0];
  assign in_time   = s_tdata[47:32];
  assign s_tready  = (state == lrg_pkg::ST_IDLE);
  assign s_fire    = s_tvalid && s_tready;
  assign m_tvalid  = (state == lrg_pkg::ST_OUT);
  assign m_tdata   = sample;
  assign cfg_ready = 1'b1;

  assign n_raw    = N_W'(in_time * ticks_per_ms);
  assign n_val    = (n_raw == '0) ? N_W'(1) : n_raw;
  assign tgt_acc  = ACC_W'(in_target) <<< SHIFT;
  assign ramp_acc = ACC_W'(ramp_target) <<< SHIFT;
  assign acc_sh   = accum_value >>> SHIFT;
  assign diff     = (DW'(in_target) <<< SHIFT) - DW'(accum_value);
  assign diff_mag = diff[DW-1] ? DW'(-diff) : DW'(diff);

  assign trial = {rem, dvd[DW-1]} - {1'b0, ticks_remaining};
  assign qbit  = !trial[N_W];

  always_comb begin
    state_next = state;
    unique case (state)
      lrg_pkg::ST_IDLE: begin
        if (s_fire && (cmd == lrg_pkg::CMD_TICK)) begin
          if ((in_target != last_target) && (in_time != '0)) begin
            state_next = lrg_pkg::ST_DIV;
          end else begin
            state_next = lrg_pkg::ST_TICK;
          end
        end
      end
      lrg_pkg::ST_DIV: begin
        if (cnt == CNT_W'(1)) begin
          state_next = lrg_pkg::ST_TICK;
        end
      end
      lrg_pkg::ST_TICK: state_next = lrg_pkg::ST_OUT;
      lrg_pkg::ST_OUT: begin
        if (m_tready) begin
          state_next = lrg_pkg::ST_IDLE;
        end
      end
      default: state_next = lrg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= lrg_pkg::ST_IDLE;
      ticks_per_ms    <= lrg_pkg::TPM_RESET;
      accum_value     <= '0;
      ramp_target     <= '0;
      last_target     <= '0;
      step_size       <= '0;
      ticks_remaining <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        ticks_per_ms <= cfg_data;
      end
      unique case (state)
        lrg_pkg::ST_IDLE: begin
          if (s_fire) begin
            if (cmd == lrg_pkg::CMD_STOP) begin
              ramp_target     <= acc_sh[Q_W-1:0];
              ticks_remaining <= '0;
            end else begin
              last_target <= in_target;
              if (in_target != last_target) begin
                ramp_target <= in_target;
                if (in_time == '0) begin
                  accum_value     <= tgt_acc;
                  ticks_remaining <= '0;
                end else begin
                  ticks_remaining <= n_val;
                end
              end
            end
          end
        end
        lrg_pkg::ST_DIV: begin
          if (cnt == CNT_W'(1)) begin
            step_size <= neg ? DW'(-$signed({dvd[DW-2:0], qbit}))
                             : $signed({dvd[DW-2:0], qbit});
          end
        end
        lrg_pkg::ST_TICK: begin
          if (ticks_remaining != '0) begin
            accum_value     <= accum_value + ACC_W'(step_size);
            ticks_remaining <= ticks_remaining - N_W'(1);
          end else begin
            accum_value <= ramp_acc;
          end
        end
        lrg_pkg::ST_OUT: ;
        default: ;
      endcase
    end
  end

  // divider datapath and sample register
  always_ff @(posedge clk) begin
    if (s_fire) begin
      dvd <= diff_mag;
      neg <= diff[DW-1];
      rem <= '0;
      cnt <= CNT_W'(DW);
    end else if (state == lrg_pkg::ST_DIV) begin
      dvd <= {dvd[DW-2:0], qbit};
      rem <= qbit ? trial[N_W-1:0] : {rem[N_W-2:0], dvd[DW-1]};
      cnt <= cnt - CNT_W'(1);
    end
    if (state == lrg_pkg::ST_TICK) begin
      sample <= (ticks_remaining != '0) ? acc_sh[Q_W-1:0] : ramp_target;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lrg_chk.sv -----
// Port-level checker for the linear ramp generator core, with its bind.
// Depends on linear_ramp_generator_core_assert.svh and lrg_pkg.
`default_nettype none

`include "linear_ramp_generator_core_assert.svh"

module lrg_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata
);

  `LRG_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `LRG_ASSERT_NEXT(a_busy_after_tick, s_tvalid && s_tready && (s_tuser == lrg_pkg::CMD_TICK), !s_tready)
  `LRG_ASSERT_IMPL(a_one_in_flight, m_tvalid, !s_tready)

endmodule

bind linear_ramp_generator_core lrg_chk u_lrg_chk (.*);

`default_nettype wire
